>>> rtl/srd_pkg.sv
// Sensor record deframer package: record kinds, status codes, record sizes
// and the queue entry passed from the parser to the output stage.
// No dependencies.
`default_nettype none
package srd_pkg;

  localparam logic [2:0] KIND_DIAG      = 3'd0;
  localparam logic [2:0] KIND_ODO       = 3'd1;
  localparam logic [2:0] KIND_GYRO      = 3'd2;
  localparam logic [2:0] KIND_GYRO_TEMP = 3'd3;
  localparam logic [2:0] KIND_ACC       = 3'd4;
  localparam logic [2:0] KIND_ACC_TEMP  = 3'd5;
  localparam logic [2:0] KIND_WHEEL     = 3'd6;
  localparam logic [2:0] KIND_NONE      = 3'd7;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
  localparam logic [2:0] ST_TOO_MANY   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;

  localparam int          RECORD_BYTES    = 10;
  localparam logic [15:0] RECORD_LIMIT_RST = 16'd30;
  localparam logic [15:0] ODO_WRAP        = 16'h0400;
  localparam logic [15:0] ODO_NEG_EDGE    = 16'hFC00;
  localparam logic [1:0]  HDR_DONE        = 2'd3;

  // One parsed transaction on its way to the output stage
  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] time_stamp;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic [15:0] third_value;
    logic [7:0]  flag_byte;
    logic [2:0]  status;
    logic        msg_end;
  } entry_t;

  // Record length in bytes, type byte included
  function automatic logic [3:0] kind_size(input logic [2:0] kind);
    logic [3:0] sz;
    unique case (kind)
      KIND_DIAG:      sz = 4'd6;
      KIND_ODO:       sz = 4'd7;
      KIND_GYRO:      sz = 4'd10;
      KIND_GYRO_TEMP: sz = 4'd6;
      KIND_ACC:       sz = 4'd10;
      KIND_ACC_TEMP:  sz = 4'd6;
      KIND_WHEEL:     sz = 4'd9;
      default:        sz = 4'd6;
    endcase
    return sz;
  endfunction

endpackage
`default_nettype wire

>>> rtl/srd_front.sv
// Parser front end: header decode, record byte capture and status tracking.
// Depends on srd_pkg; pushes finished records and message ends into the queue.
`default_nettype none
module srd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  input  wire logic [15:0]    cfg_data,
  input  wire logic           accept,
  input  wire logic [7:0]     byte_value,
  input  wire logic           end_of_message,
  output srd_pkg::entry_t     push_entry,
  output logic                push
);

  logic [15:0] record_limit;
  logic [1:0]  header_position, header_position_next;
  logic [15:0] records_remaining, records_remaining_next;
  logic [3:0]  record_byte_index, record_byte_index_next;
  logic [2:0]  current_kind, current_kind_next;
  logic [2:0]  parse_status, parse_status_next;
  logic        parse_finished, parse_finished_next;
  logic [7:0]  record_bytes [srd_pkg::RECORD_BYTES];
  logic [7:0]  cur [srd_pkg::RECORD_BYTES];
  logic        write_byte;
  logic        have_rec;
  logic [3:0]  index_inc;
  logic [2:0]  end_status;

  assign index_inc = record_byte_index + 4'd1;

  // Parse one byte
  always_comb begin
    header_position_next   = header_position;
    records_remaining_next = records_remaining;
    record_byte_index_next = record_byte_index;
    current_kind_next      = current_kind;
    parse_status_next      = parse_status;
    parse_finished_next    = parse_finished;
    write_byte             = 1'b0;
    have_rec               = 1'b0;
    if (!parse_finished) begin
      if (header_position != srd_pkg::HDR_DONE) begin
        if (header_position == 2'd1) begin
          records_remaining_next = {8'd0, byte_value};
        end else if (header_position == 2'd2) begin
          records_remaining_next = {byte_value, records_remaining[7:0]};
          if (records_remaining_next >= record_limit) begin
            parse_status_next   = srd_pkg::ST_TOO_MANY;
            parse_finished_next = 1'b1;
          end else if (records_remaining_next == 16'd0) begin
            parse_finished_next = 1'b1;
          end
        end
        header_position_next = header_position + 2'd1;
      end else if (record_byte_index == 4'd0) begin
        if (byte_value > {5'd0, srd_pkg::KIND_WHEEL}) begin
          parse_status_next   = srd_pkg::ST_UNKNOWN;
          parse_finished_next = 1'b1;
        end else begin
          current_kind_next      = byte_value[2:0];
          record_byte_index_next = 4'd1;
        end
      end else begin
        write_byte             = 1'b1;
        record_byte_index_next = index_inc;
        if (index_inc >= srd_pkg::kind_size(current_kind)) begin
          have_rec               = 1'b1;
          record_byte_index_next = 4'd0;
          records_remaining_next = records_remaining - 16'd1;
          if (records_remaining_next == 16'd0) parse_finished_next = 1'b1;
        end
      end
    end
    end_status = parse_status_next;
    if (!parse_finished_next) begin
      end_status = (header_position_next != srd_pkg::HDR_DONE) ?
                   srd_pkg::ST_SHORT_HDR : srd_pkg::ST_TRUNCATED;
    end
  end

  // Record bytes with the current byte folded in
  always_comb begin
    for (int j = 0; j < srd_pkg::RECORD_BYTES; j++) begin
      cur[j] = (write_byte && record_byte_index == 4'(j)) ? byte_value : record_bytes[j];
    end
  end

  // Build the queue entry
  always_comb begin
    push_entry              = '0;
    push_entry.kind         = have_rec ? current_kind : srd_pkg::KIND_NONE;
    if (have_rec) begin
      push_entry.time_stamp  = {cur[3], cur[2], cur[1]};
      push_entry.first_value = {cur[5], cur[4]};
      unique case (current_kind)
        srd_pkg::KIND_GYRO, srd_pkg::KIND_ACC: begin
          push_entry.second_value = {cur[7], cur[6]};
          push_entry.third_value  = {cur[9], cur[8]};
        end
        srd_pkg::KIND_ODO: begin
          push_entry.flag_byte = cur[6];
        end
        srd_pkg::KIND_WHEEL: begin
          push_entry.second_value = {cur[7], cur[6]};
          push_entry.flag_byte    = cur[8];
        end
        default: ;
      endcase
    end
    if (end_of_message) begin
      push_entry.status  = end_status;
      push_entry.msg_end = 1'b1;
    end
  end

  assign push = accept && (have_rec || end_of_message);

  // Capture record bytes
  always_ff @(posedge clk) begin
    if (accept && write_byte) record_bytes[record_byte_index] <= byte_value;
  end

  // Advance parser state; clear per message on its final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      record_limit      <= srd_pkg::RECORD_LIMIT_RST;
      header_position   <= '0;
      records_remaining <= '0;
      record_byte_index <= '0;
      current_kind      <= '0;
      parse_status      <= '0;
      parse_finished    <= 1'b0;
    end else begin
      if (cfg_valid) record_limit <= cfg_data;
      if (accept) begin
        if (end_of_message) begin
          header_position   <= '0;
          records_remaining <= '0;
          record_byte_index <= '0;
          current_kind      <= '0;
          parse_status      <= '0;
          parse_finished    <= 1'b0;
        end else begin
          header_position   <= header_position_next;
          records_remaining <= records_remaining_next;
          record_byte_index <= record_byte_index_next;
          current_kind      <= current_kind_next;
          parse_status      <= parse_status_next;
          parse_finished    <= parse_finished_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/srd_queue.sv
// Short queue of parsed entries between parser and output stage.
// Depends on srd_pkg for the entry type.
`default_nettype none
module srd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire srd_pkg::entry_t push_entry,
  input  wire logic            pop,
  output srd_pkg::entry_t      head,
  output logic                 empty,
  output logic                 full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  srd_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_entry;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/srd_back.sv
// Output stage: odometer delta, wheel status decode and the result register.
// Depends on srd_pkg; pops entries from the queue.
`default_nettype none
module srd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire srd_pkg::entry_t head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [2:0]           record_kind,
  output logic [23:0]          time_stamp,
  output logic [15:0]          first_value,
  output logic [15:0]          second_value,
  output logic [15:0]          third_value,
  output logic [7:0]           flag_byte,
  output logic [15:0]          odo_delta,
  output logic                 rear_right_invalid,
  output logic                 rear_left_invalid,
  output logic [1:0]           drive_direction,
  output logic [2:0]           message_status,
  output logic                 message_end
);

  logic        odo_started;
  logic [15:0] odo_last_count;
  logic        is_odo;
  logic        is_wheel;
  logic [15:0] diff;
  logic [15:0] delta;
  logic [1:0]  dir;

  assign pop      = !empty && (!out_valid || out_ready);
  assign is_odo   = (head.kind == srd_pkg::KIND_ODO);
  assign is_wheel = (head.kind == srd_pkg::KIND_WHEEL);
  assign diff     = head.first_value - odo_last_count;

  // Fold negative counter steps once by 1024, then take the magnitude
  always_comb begin
    if (!odo_started)                     delta = head.first_value;
    else if (!diff[15])                   delta = diff;
    else if (diff >= srd_pkg::ODO_NEG_EDGE) delta = diff + srd_pkg::ODO_WRAP;
    else                                  delta = srd_pkg::ODO_NEG_EDGE - diff;
  end

  // Decode drive direction from status bits 3:2
  always_comb begin
    unique case (head.flag_byte[3:2])
      2'b01:   dir = 2'd1;
      2'b10:   dir = 2'd2;
      default: dir = 2'd0;
    endcase
  end

  // Hold odometer history across messages
  always_ff @(posedge clk) begin
    if (rst) begin
      odo_started    <= 1'b0;
      odo_last_count <= '0;
    end else if (pop && is_odo) begin
      odo_started    <= 1'b1;
      odo_last_count <= head.first_value;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (pop) begin
      record_kind        <= head.kind;
      time_stamp         <= head.time_stamp;
      first_value        <= head.first_value;
      second_value       <= head.second_value;
      third_value        <= head.third_value;
      flag_byte          <= head.flag_byte;
      odo_delta          <= is_odo ? delta : 16'd0;
      rear_right_invalid <= is_wheel & head.flag_byte[0];
      rear_left_invalid  <= is_wheel & head.flag_byte[1];
      drive_direction    <= is_wheel ? dir : 2'd0;
      message_status     <= head.status;
      message_end        <= head.msg_end;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sensor_record_deframer_top.sv
// Sensor record deframer top level: parser, entry queue and output stage.
// Depends on srd_pkg, srd_front, srd_queue and srd_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one message byte per
//   transaction with end_of_message on the final byte. The output channel
//   (out_valid/out_ready) gives one result per finished record and one on
//   the final byte of each message (message_end = 1 with message_status);
//   a record finished by the final byte shares that result.
//   Configuration channel (cfg_valid/cfg_ready, cfg_data) writes the record
//   limit; it is always ready. It must be written only while the block is
//   idle; the user is bound to this, the block itself does not enforce it.
//   Throughput: one byte per cycle while in_ready is high. A result is
//   queued when its byte is accepted, then loaded into the output register.
//   A stalled receiver holds the output register; the queue of QUEUE_DEPTH
//   entries keeps taking bytes until it fills, then in_ready drops.
//   Reset sets the record limit to 30, clears the parser, the queue and the
//   odometer history; it needs no clearing pass.
`default_nettype none
module sensor_record_deframer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   byte_value,
  input  wire logic         end_of_message,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        record_kind,
  output logic [23:0]       time_stamp,
  output logic [15:0]       first_value,
  output logic [15:0]       second_value,
  output logic [15:0]       third_value,
  output logic [7:0]        flag_byte,
  output logic [15:0]       odo_delta,
  output logic              rear_right_invalid,
  output logic              rear_left_invalid,
  output logic [1:0]        drive_direction,
  output logic [2:0]        message_status,
  output logic              message_end
);

  srd_pkg::entry_t push_entry;
  srd_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;

  srd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .byte_value     (byte_value),
    .end_of_message (end_of_message),
    .push_entry     (push_entry),
    .push           (push)
  );

  srd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  srd_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head               (head),
    .empty              (empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .record_kind        (record_kind),
    .time_stamp         (time_stamp),
    .first_value        (first_value),
    .second_value       (second_value),
    .third_value        (third_value),
    .flag_byte          (flag_byte),
    .odo_delta          (odo_delta),
    .rear_right_invalid (rear_right_invalid),
    .rear_left_invalid  (rear_left_invalid),
    .drive_direction    (drive_direction),
    .message_status     (message_status),
    .message_end        (message_end)
  );

endmodule
`default_nettype wire

>>> tb/tb_sensor_record_deframer_top.sv
// Self-checking testbench for sensor_record_deframer_top: directed messages with set results,
// then random message streams under several record limits checked against a local predictor.
// Depends on srd_pkg and the deframer RTL.
`default_nettype none
module tb_sensor_record_deframer_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 500;
  localparam int NUM_PHASES  = 7;
  localparam int DRAIN_TAIL  = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int ODO_SPAN    = 1024;

  localparam logic [1:0] DIR_UNKNOWN = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  // Record length in bytes per kind, type byte included
  localparam logic [3:0] REC_LEN [0:6] = '{4'd6, 4'd7, 4'd10, 4'd6, 4'd10, 4'd6, 4'd9};

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] stamp;
    logic [15:0] first;
    logic [15:0] second;
    logic [15:0] third;
    logic [7:0]  flags;
    logic [15:0] odo_step;
    logic        rr_bad;
    logic        rl_bad;
    logic [1:0]  direction;
    logic [2:0]  status;
    logic        msg_end;
  } rec_result_t;

  typedef struct {
    logic [7:0]  b;
    logic        e;
    bit          known;
    rec_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_value;
  logic        end_of_message;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  record_kind;
  logic [23:0] time_stamp;
  logic [15:0] first_value;
  logic [15:0] second_value;
  logic [15:0] third_value;
  logic [7:0]  flag_byte;
  logic [15:0] odo_delta;
  logic        rear_right_invalid;
  logic        rear_left_invalid;
  logic [1:0]  drive_direction;
  logic [2:0]  message_status;
  logic        message_end;

  sensor_record_deframer_top dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .byte_value         (byte_value),
    .end_of_message     (end_of_message),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .record_kind        (record_kind),
    .time_stamp         (time_stamp),
    .first_value        (first_value),
    .second_value       (second_value),
    .third_value        (third_value),
    .flag_byte          (flag_byte),
    .odo_delta          (odo_delta),
    .rear_right_invalid (rear_right_invalid),
    .rear_left_invalid  (rear_left_invalid),
    .drive_direction    (drive_direction),
    .message_status     (message_status),
    .message_end        (message_end)
  );

  always #5 clk = ~clk;

  // Predictor state: parser position, record buffer, odometer history, limit
  logic [1:0]  hdr_pos;
  logic [15:0] recs_left;
  logic [3:0]  byte_idx;
  logic [2:0]  cur_kind;
  logic [7:0]  rec_buf [0:9];
  logic [2:0]  msg_state;
  logic        msg_done;
  logic        odo_seen;
  logic [15:0] odo_prev;
  logic [15:0] rec_limit;

  rec_result_t pending_results [$];
  logic [7:0]  msg_q [$];
  stim_row_t   plan [$];
  logic [15:0] odo_hint;

  bit src_gaps;
  bit sink_gaps;
  int sink_hold;
  int quiet_cycles;
  int errors;
  int msgs_sent;
  int bytes_sent;
  int results_checked;
  int kind_seen [0:7];
  int status_seen [0:4];
  rec_result_t got;
  rec_result_t want;

  // Advance the parser by one byte; return 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, input logic eom,
                                    output rec_result_t r);
    bit          have;
    logic [15:0] cnt;
    logic [15:0] diff;
    int          sd;
    logic [7:0]  st;
    have = 1'b0;
    r = '0;
    if (!msg_done) begin
      if (hdr_pos != srd_pkg::HDR_DONE) begin
        if (hdr_pos == 2'd1) begin
          recs_left = {8'h00, b};
        end else if (hdr_pos == 2'd2) begin
          recs_left[15:8] = b;
          if (recs_left >= rec_limit) begin
            msg_state = srd_pkg::ST_TOO_MANY;
            msg_done = 1'b1;
          end else if (recs_left == 16'd0) begin
            msg_done = 1'b1;
          end
        end
        hdr_pos = hdr_pos + 2'd1;
      end else if (byte_idx == 4'd0) begin
        if (b > {5'd0, srd_pkg::KIND_WHEEL}) begin
          msg_state = srd_pkg::ST_UNKNOWN;
          msg_done = 1'b1;
        end else begin
          cur_kind = b[2:0];
          rec_buf[0] = b;
          byte_idx = 4'd1;
        end
      end else begin
        if (byte_idx < 4'd10) rec_buf[byte_idx] = b;
        byte_idx = byte_idx + 4'd1;
        if (byte_idx >= REC_LEN[cur_kind]) begin
          // Record complete: unpack the fields for its kind
          r.kind = cur_kind;
          r.stamp = {rec_buf[3], rec_buf[2], rec_buf[1]};
          r.first = {rec_buf[5], rec_buf[4]};
          if (cur_kind == srd_pkg::KIND_GYRO || cur_kind == srd_pkg::KIND_ACC) begin
            r.second = {rec_buf[7], rec_buf[6]};
            r.third = {rec_buf[9], rec_buf[8]};
          end else if (cur_kind == srd_pkg::KIND_ODO) begin
            cnt = {rec_buf[5], rec_buf[4]};
            r.flags = rec_buf[6];
            if (!odo_seen) begin
              odo_seen = 1'b1;
              r.odo_step = cnt;
            end else begin
              // Signed difference, folded once by the counter span, then magnitude
              diff = cnt - odo_prev;
              sd = $signed(diff);
              if (sd < 0) sd = sd + ODO_SPAN;
              if (sd < 0) sd = -sd;
              r.odo_step = sd[15:0];
            end
            odo_prev = cnt;
          end else if (cur_kind == srd_pkg::KIND_WHEEL) begin
            st = rec_buf[8];
            r.second = {rec_buf[7], rec_buf[6]};
            r.flags = st;
            r.rr_bad = st[0];
            r.rl_bad = st[1];
            if (st[3:2] == 2'b01) r.direction = DIR_FORWARD;
            else if (st[3:2] == 2'b10) r.direction = DIR_REVERSE;
            else r.direction = DIR_UNKNOWN;
          end
          have = 1'b1;
          byte_idx = 4'd0;
          recs_left = recs_left - 16'd1;
          if (recs_left == 16'd0) msg_done = 1'b1;
        end
      end
    end
    if (!have) r.kind = srd_pkg::KIND_NONE;
    if (eom) begin
      if (msg_done) r.status = msg_state;
      else if (hdr_pos != srd_pkg::HDR_DONE) r.status = srd_pkg::ST_SHORT_HDR;
      else r.status = srd_pkg::ST_TRUNCATED;
      r.msg_end = 1'b1;
      hdr_pos = 2'd0;
      recs_left = 16'd0;
      byte_idx = 4'd0;
      cur_kind = srd_pkg::KIND_DIAG;
      msg_state = srd_pkg::ST_OK;
      msg_done = 1'b0;
      have = 1'b1;
    end
    return have;
  endfunction

  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic rec_result_t end_only(input logic [2:0] st);
    rec_result_t r;
    r = '0;
    r.kind = srd_pkg::KIND_NONE;
    r.status = st;
    r.msg_end = 1'b1;
    return r;
  endfunction

  // Present one byte, hold it until accepted, then log what it should produce
  task automatic send_byte(input logic [7:0] b, input logic e, input bit known,
                           input rec_result_t known_res);
    rec_result_t r;
    bit          have;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_value <= b;
    end_of_message <= e;
    do @(posedge clk); while (!in_ready);
    have = parse_byte(b, e, r);
    if (known) pending_results.push_back(known_res);
    else if (have) pending_results.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_message();
    rec_result_t none;
    none = '0;
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1, 1'b0, none);
    msgs_sent++;
  endtask

  // Hold the sender until every pending result is out, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    rec_limit = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] b, input logic e);
    stim_row_t row;
    row.b = b;
    row.e = e;
    row.known = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endtask

  task automatic add_known(input logic [7:0] b, input logic e, input rec_result_t w);
    stim_row_t row;
    row.b = b;
    row.e = e;
    row.known = 1'b1;
    row.want = w;
    plan.push_back(row);
  endtask

  task automatic put_header(input logic [15:0] count);
    msg_q.push_back(rand_byte());
    msg_q.push_back(count[7:0]);
    msg_q.push_back(count[15:8]);
  endtask

  // Append one complete record; odometer counters stay near the last one half the time
  task automatic put_record(input logic [2:0] k);
    logic [15:0] cnt;
    msg_q.push_back({5'd0, k});
    repeat (3) msg_q.push_back(rand_byte());
    if (k == srd_pkg::KIND_ODO) begin
      case ($urandom_range(0, 3))
        0: cnt = odo_hint + 16'($urandom_range(0, 40));
        1: cnt = odo_hint - 16'($urandom_range(1, 40));
        2: cnt = odo_hint - 16'($urandom_range(1000, 1100));
        default: cnt = 16'($urandom);
      endcase
      odo_hint = cnt;
      msg_q.push_back(cnt[7:0]);
      msg_q.push_back(cnt[15:8]);
      msg_q.push_back(rand_byte());
    end else begin
      for (int i = 4; i < REC_LEN[k]; i++) msg_q.push_back(rand_byte());
    end
  endtask

  // Compose one random message, mostly well formed, some broken
  task automatic build_message();
    int          sel;
    int          n;
    int          cut;
    int          max_n;
    logic [15:0] count;
    msg_q.delete();
    sel = $urandom_range(0, 9);
    max_n = (rec_limit > 16'd7) ? 6 : int'(rec_limit) - 1;
    if (max_n < 1 && sel <= 8) sel = 9;
    if (sel <= 8) begin
      n = $urandom_range(1, max_n);
      put_header(16'(n));
      if (sel == 8) begin
        // Unknown type byte at some record boundary
        repeat ($urandom_range(0, n - 1)) put_record(3'($urandom_range(0, 6)));
        msg_q.push_back(8'($urandom_range(7, 255)));
        repeat ($urandom_range(0, 4)) msg_q.push_back(rand_byte());
      end else begin
        repeat (n) put_record(3'($urandom_range(0, 6)));
        if (sel == 7) begin
          // Truncate anywhere after the header
          cut = $urandom_range(3, msg_q.size() - 1);
          while (msg_q.size() > cut) void'(msg_q.pop_back());
        end else if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) msg_q.push_back(rand_byte());
        end
      end
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          count = 16'($urandom_range(int'(rec_limit), 65535));
          put_header(count);
          repeat ($urandom_range(0, 8)) msg_q.push_back(rand_byte());
        end
        1: begin
          put_header(16'd0);
          repeat ($urandom_range(0, 4)) msg_q.push_back(rand_byte());
        end
        default: begin
          repeat ($urandom_range(1, 2)) msg_q.push_back(rand_byte());
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] w, input logic [23:0] g);
    if (w !== g) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, w, g);
      errors++;
    end
  endtask

  // Receiver: random stall bursts while enabled
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest pending result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = '{record_kind, time_stamp, first_value, second_value, third_value, flag_byte,
              odo_delta, rear_right_invalid, rear_left_invalid, drive_direction,
              message_status, message_end};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0d end %0b", $time, got.kind, got.msg_end);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("record_kind", 24'(want.kind), 24'(got.kind));
        check_field("time_stamp", want.stamp, got.stamp);
        check_field("first_value", 24'(want.first), 24'(got.first));
        check_field("second_value", 24'(want.second), 24'(got.second));
        check_field("third_value", 24'(want.third), 24'(got.third));
        check_field("flag_byte", 24'(want.flags), 24'(got.flags));
        check_field("odo_delta", 24'(want.odo_step), 24'(got.odo_step));
        check_field("rear_right_invalid", 24'(want.rr_bad), 24'(got.rr_bad));
        check_field("rear_left_invalid", 24'(want.rl_bad), 24'(got.rl_bad));
        check_field("drive_direction", 24'(want.direction), 24'(got.direction));
        check_field("message_status", 24'(want.status), 24'(got.status));
        check_field("message_end", 24'(want.msg_end), 24'(got.msg_end));
      end
      results_checked++;
      kind_seen[got.kind]++;
      if (got.msg_end && got.status <= srd_pkg::ST_TRUNCATED) status_seen[got.status]++;
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] phase_lim [0:NUM_PHASES-1];
    rec_result_t odo_first;
    int          phase_start;

    in_valid <= 1'b0;
    byte_value <= 8'h00;
    end_of_message <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= 16'h0000;
    rst <= 1'b1;

    hdr_pos = 2'd0;
    recs_left = 16'd0;
    byte_idx = 4'd0;
    cur_kind = srd_pkg::KIND_DIAG;
    msg_state = srd_pkg::ST_OK;
    msg_done = 1'b0;
    odo_seen = 1'b0;
    odo_prev = 16'd0;
    rec_limit = srd_pkg::RECORD_LIMIT_RST;
    odo_hint = 16'd0;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    sink_hold = 0;
    quiet_cycles = 0;
    errors = 0;
    msgs_sent = 0;
    bytes_sent = 0;
    results_checked = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed messages under the reset limit
    add_known(8'h00, 1'b1, end_only(srd_pkg::ST_SHORT_HDR));
    add_row(8'h01, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_known(8'h06, 1'b1, end_only(srd_pkg::ST_TOO_MANY));
    add_row(8'hFF, 1'b0);
    add_row(8'h00, 1'b0);
    add_known(8'h00, 1'b1, end_only(srd_pkg::ST_OK));
    // First odometer record after reset reports the raw counter, on the final byte
    odo_first = '0;
    odo_first.kind = srd_pkg::KIND_ODO;
    odo_first.stamp = 24'hFFFFFF;
    odo_first.first = 16'hFFFF;
    odo_first.flags = 8'hFF;
    odo_first.odo_step = 16'hFFFF;
    odo_first.status = srd_pkg::ST_OK;
    odo_first.msg_end = 1'b1;
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h00, 1'b0);
    add_row({5'd0, srd_pkg::KIND_ODO}, 1'b0);
    repeat (5) add_row(8'hFF, 1'b0);
    add_known(8'hFF, 1'b1, odo_first);
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h00, 1'b0);
    add_known(8'h07, 1'b1, end_only(srd_pkg::ST_UNKNOWN));
    add_row(8'h00, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h00, 1'b0);
    add_known({5'd0, srd_pkg::KIND_GYRO}, 1'b1, end_only(srd_pkg::ST_TRUNCATED));
    foreach (plan[i]) send_byte(plan[i].b, plan[i].e, plan[i].known, plan[i].want);
    msgs_sent += 6;

    // Random phases, each under its own record limit
    phase_lim[0] = srd_pkg::RECORD_LIMIT_RST;
    phase_lim[1] = 16'hFFFF;
    phase_lim[2] = 16'd0;
    phase_lim[3] = 16'd1;
    phase_lim[4] = 16'($urandom_range(2, 40));
    phase_lim[5] = 16'd3;
    phase_lim[6] = srd_pkg::RECORD_LIMIT_RST;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p != 0) write_limit(phase_lim[p]);
      src_gaps = (p % 3 != 2) && (p != NUM_PHASES - 1);
      sink_gaps = (p != 3) && (p != NUM_PHASES - 1);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RAND_ITEMS / NUM_PHASES) begin
        build_message();
        send_message();
      end
    end

    wait_idle();
    $display("Covered %0d messages, %0d bytes, %0d results, limits 0 to 65535.",
             msgs_sent, bytes_sent, results_checked);
    $display("Kinds %0d %0d %0d %0d %0d %0d %0d none %0d; end statuses %0d %0d %0d %0d %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], kind_seen[6], kind_seen[7], status_seen[0], status_seen[1],
             status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
